/* src/xkb64_pkg.sv */
// shared types, constants and the base64 alphabet for the xor/base64 encoder
`default_nettype none

package xkb64_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;

  // ascii '=' used for padding
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // group queue depth and derived widths
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // up to four characters made from one input byte
  typedef struct packed {
    logic [3:0][7:0] chr;
    logic [1:0]      last_idx;
    logic            last;
  } char_group_t;

  // queue status seen by the back end and the checks
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_status_t;

  // standard base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = w + 8'd65;
    end else if (v < 6'd52) begin
      r = w + 8'd71;
    end else if (v < 6'd62) begin
      r = w - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/xor_key_base64_encoder.sv */
// repeating-key xor followed by base64 encoding, bytes in, characters out
// a byte's group is written into the group queue, and its characters leave through the output register
// throughput: one character per cycle at the output register while out_tready allows; a
//   byte makes 1 or 2 characters (up to 4 on the last byte)
// the four-entry group queue lets the input run ahead while characters drain
// reset (rst_n low, synchronous) clears key position, bit state, queue and output
`default_nettype none

module xor_key_base64_encoder #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] base64_char
  output logic             out_tlast,  // last_char
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [8*MAX_KEY_BYTES-1:0] key_bytes_r;
  logic [3:0]                 key_length_r;
  logic                       in_take;
  logic                       q_pop;
  xkb64_pkg::char_group_t     f_grp;
  xkb64_pkg::char_group_t     q_head;
  xkb64_pkg::q_status_t       q_st;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_st.full;
  assign in_take   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xkb64_pkg::REG_KEY_BYTES:  key_bytes_r  <= cfg_data[8*MAX_KEY_BYTES-1:0];
        xkb64_pkg::REG_KEY_LENGTH: key_length_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  xkb64_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_bytes  (key_bytes_r),
    .key_length (key_length_r),
    .in_take    (in_take),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .grp        (f_grp)
  );

  xkb64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_grp (f_grp),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_st)
  );

  xkb64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_st      (q_st),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

`ifndef SYNTHESIS
  // queue level never exceeds its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.level <= xkb64_pkg::QLVL_W'(xkb64_pkg::QUEUE_DEPTH))
    else $error("group queue level beyond depth");

  // no group leaves an empty queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("pop from empty group queue");

  // a push and a pop at once keep the level
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && q_pop) |=> $stable(q_st.level))
    else $error("queue level moved on push with pop");
`endif

endmodule

`default_nettype wire

/* src/xkb64_front.sv */
// front end: key xor, bit packing into sextets and padding, one group per byte
`default_nettype none

module xkb64_front #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [8*MAX_KEY_BYTES-1:0]   key_bytes,
  input  wire logic [3:0]                   key_length,
  input  wire logic                         in_take,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         last_byte,
  output xkb64_pkg::char_group_t            grp
);

  localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_KEY_BYTES);

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_TWO  = 2'd1,
    PH_FOUR = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         pend_r, pend_nxt;
  logic [KPW-1:0]     pos_r, pos_nxt;

  logic [MAX_KEY_BYTES-1:0][7:0] key_arr;
  logic [3:0]         len_eff;
  logic [KPW-1:0]     pos_eff;
  logic [3:0]         pos_inc;
  logic [7:0]         b;
  phase_t             phase_mid;
  logic [3:0]         pend_mid;
  logic [1:0]         cnt;

  assign key_arr = key_bytes;

  // effective key length and position
  always_comb begin
    if (key_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (key_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = key_length;
    end
    pos_eff = (4'(pos_r) >= len_eff) ? '0 : pos_r;
    pos_inc = 4'(pos_eff) + 4'd1;
    b       = data_byte ^ key_arr[pos_eff];
  end

  // sextet formation, flush and padding
  always_comb begin
    grp       = '0;
    cnt       = 2'd0;
    phase_mid = PH_NONE;
    pend_mid  = 4'd0;
    case (phase_r)
      PH_TWO: begin
        grp.chr[0] = xkb64_pkg::b64_char({pend_r[1:0], b[7:4]});
        pend_mid   = b[3:0];
        phase_mid  = PH_FOUR;
        cnt        = 2'd0;
      end
      PH_FOUR: begin
        grp.chr[0] = xkb64_pkg::b64_char({pend_r, b[7:6]});
        grp.chr[1] = xkb64_pkg::b64_char(b[5:0]);
        pend_mid   = 4'd0;
        phase_mid  = PH_NONE;
        cnt        = 2'd1;
      end
      default: begin
        grp.chr[0] = xkb64_pkg::b64_char(b[7:2]);
        pend_mid   = {2'b00, b[1:0]};
        phase_mid  = PH_TWO;
        cnt        = 2'd0;
      end
    endcase

    grp.last_idx = cnt;
    grp.last     = last_byte;
    phase_nxt    = phase_mid;
    pend_nxt     = pend_mid;
    pos_nxt      = (pos_inc >= len_eff) ? '0 : KPW'(pos_inc);

    // final byte: flush the partial sextet and pad to four characters
    if (last_byte) begin
      if (phase_mid == PH_TWO) begin
        grp.chr[1]   = xkb64_pkg::b64_char({pend_mid[1:0], 4'b0000});
        grp.chr[2]   = xkb64_pkg::PAD_CHAR;
        grp.chr[3]   = xkb64_pkg::PAD_CHAR;
        grp.last_idx = 2'd3;
      end else if (phase_mid == PH_FOUR) begin
        grp.chr[1]   = xkb64_pkg::b64_char({pend_mid, 2'b00});
        grp.chr[2]   = xkb64_pkg::PAD_CHAR;
        grp.last_idx = 2'd2;
      end
      phase_nxt = PH_NONE;
      pend_nxt  = 4'd0;
      pos_nxt   = '0;
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      pend_r  <= 4'd0;
      pos_r   <= '0;
    end else if (in_take) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/xkb64_queue.sv */
// short queue of character groups between front and back end
`default_nettype none

module xkb64_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  xkb64_pkg::char_group_t      push_grp,
  input  wire logic                   pop,
  output xkb64_pkg::char_group_t      head,
  output xkb64_pkg::q_status_t        status
);

  localparam int D  = xkb64_pkg::QUEUE_DEPTH;
  localparam int PW = xkb64_pkg::QPTR_W;
  localparam int LW = xkb64_pkg::QLVL_W;

  xkb64_pkg::char_group_t mem [D];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] level_r;

  assign head         = mem[rd_ptr_r];
  assign status.level = level_r;
  assign status.full  = (level_r == LW'(D));
  assign status.empty = (level_r == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_grp;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/xkb64_back.sv */
// back end: serializes one character per cycle into the output register when out_ready allows
`default_nettype none

module xkb64_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  xkb64_pkg::char_group_t      head,
  input  xkb64_pkg::q_status_t        q_st,
  output logic                        pop,
  output logic                        out_valid,
  output logic [7:0]                  out_char,
  output logic                        out_last,
  input  wire logic                   out_ready
);

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       take;
  logic       at_end;

  assign load      = !out_valid_r || out_ready;
  assign take      = load && !q_st.empty;
  assign at_end    = (idx_r == head.last_idx);
  assign pop       = take && at_end;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // output register and character index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= !q_st.empty;
      end
      if (take) begin
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_char_r <= head.chr[idx_r];
      out_last_r <= head.last && at_end;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_xor_key_base64_encoder.sv */
// self-checking testbench for the repeating-key xor plus base64 encoder
`timescale 1ns / 100ps

module tb_xor_key_base64_encoder;

  localparam int         KEY_SLOTS = 8;
  localparam logic [1:0] REG_NONE  = 2'd3;  // index with no register behind it
  localparam logic [8*64-1:0] B64_TABLE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // how many leftover bits wait for the next byte
  typedef enum logic [1:0] {
    BITS_NONE = 2'd0,
    BITS_TWO  = 2'd1,
    BITS_FOUR = 2'd2
  } pend_phase_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } b64_out_t;

  // one directed step: a register write or a byte, with an optional typed answer
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [63:0] val;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  nwant;
    logic [31:0] want;
  } dir_row_t;

  localparam int N_DIRECTED = 29;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // reset key: zero, length one
    '{1'b0, 2'd0, 64'd0, 8'h00, 1'b1, 3'd4, "AA=="},
    '{1'b0, 2'd0, 64'd0, 8'hFF, 1'b1, 3'd4, "/w=="},
    '{1'b0, 2'd0, 64'd0, 8'hFF, 1'b0, 3'd1, "/"},
    '{1'b0, 2'd0, 64'd0, 8'hFF, 1'b0, 3'd1, "/"},
    '{1'b0, 2'd0, 64'd0, 8'hFF, 1'b1, 3'd2, "//"},
    '{1'b0, 2'd0, 64'd0, 8'h00, 1'b0, 3'd1, "A"},
    '{1'b0, 2'd0, 64'd0, 8'h00, 1'b1, 3'd3, "AA="},
    // write to an unmapped index is dropped
    '{1'b1, REG_NONE, 64'hA5A5_5A5A_0F0F_F0F0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, xkb64_pkg::REG_KEY_BYTES, 64'hFEDC_BA98_7654_3210, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, xkb64_pkg::REG_KEY_LENGTH, 64'd3, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h41, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h42, 1'b0, 3'd0, 32'h0},
    // key shortened mid-message: position falls back to byte zero
    '{1'b1, xkb64_pkg::REG_KEY_LENGTH, 64'd1, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h43, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h44, 1'b1, 3'd0, 32'h0},
    // zero length acts as one
    '{1'b1, xkb64_pkg::REG_KEY_LENGTH, 64'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h80, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h01, 1'b1, 3'd0, 32'h0},
    // all-ones key, length above eight saturates
    '{1'b1, xkb64_pkg::REG_KEY_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, xkb64_pkg::REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'hFF, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h55, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'hAA, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h0F, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'hF0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h7E, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h81, 1'b0, 3'd0, 32'h0},
    '{1'b0, 2'd0, 64'd0, 8'h3C, 1'b1, 3'd0, 32'h0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] data_byte
  logic        in_tlast   = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] base64_char
  logic        out_tlast;            // last_char
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = 2'd0;
  logic [63:0] cfg_data   = 64'd0;

  // predictor copy of registers and encoder state
  logic [63:0] key_reg     = 64'd0;
  logic [3:0]  key_len_reg = 4'd1;
  logic [2:0]  key_pos     = 3'd0;
  logic [3:0]  pend_bits   = 4'd0;
  pend_phase_t bit_phase   = BITS_NONE;

  b64_out_t expected_chars[$];
  int       fail_count   = 0;
  logic     in_gaps_on   = 1'b1;
  logic     out_stall_on = 1'b1;

  xor_key_base64_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    return B64_TABLE[8*(63-v) +: 8];
  endfunction

  // append one expected character to the scoreboard
  task automatic queue_char(input logic [7:0] c, input logic l);
    b64_out_t e;
    e.chr  = c;
    e.last = l;
    expected_chars.insert(expected_chars.size(), e);
  endtask

  // xor with the current key byte, then emit every completed sextet; flush and pad on the last byte
  task automatic encode_byte(input logic [7:0] d, input logic l,
                             output logic [3:0][7:0] ch, output int n);
    logic [3:0] len;
    logic [2:0] pos;
    logic [7:0] b;
    ch  = '0;
    len = key_len_reg;
    if (len == 4'd0) len = 4'd1;
    if (len > KEY_SLOTS) len = 4'(KEY_SLOTS);
    pos = key_pos;
    if (pos >= len) pos = 3'd0;
    b = d ^ key_reg[8*pos +: 8];
    key_pos = (pos + 1 >= len) ? 3'd0 : pos + 3'd1;
    case (bit_phase)
      BITS_TWO: begin
        ch[0]     = b64_symbol({pend_bits[1:0], b[7:4]});
        n         = 1;
        pend_bits = b[3:0];
        bit_phase = BITS_FOUR;
      end
      BITS_FOUR: begin
        ch[0]     = b64_symbol({pend_bits, b[7:6]});
        ch[1]     = b64_symbol(b[5:0]);
        n         = 2;
        pend_bits = 4'd0;
        bit_phase = BITS_NONE;
      end
      default: begin
        ch[0]     = b64_symbol(b[7:2]);
        n         = 1;
        pend_bits = {2'b00, b[1:0]};
        bit_phase = BITS_TWO;
      end
    endcase
    // end of message: flush with zero fill and pad to a group of four
    if (l) begin
      if (bit_phase == BITS_TWO) begin
        ch[n]   = b64_symbol({pend_bits[1:0], 4'b0000});
        ch[n+1] = xkb64_pkg::PAD_CHAR;
        ch[n+2] = xkb64_pkg::PAD_CHAR;
        n       = n + 3;
      end else if (bit_phase == BITS_FOUR) begin
        ch[n]   = b64_symbol({pend_bits, 2'b00});
        ch[n+1] = xkb64_pkg::PAD_CHAR;
        n       = n + 2;
      end
      key_pos   = 3'd0;
      pend_bits = 4'd0;
      bit_phase = BITS_NONE;
    end
  endtask

  // stop sending and let every outstanding character come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == xkb64_pkg::REG_KEY_BYTES) key_reg = val;
    else if (idx == xkb64_pkg::REG_KEY_LENGTH) key_len_reg = val[3:0];
  endtask

  // one byte transfer; nwant > 0 means the characters are typed in by hand
  task automatic send_byte(input logic [7:0] d, input logic l,
                           input logic [2:0] nwant, input logic [31:0] want);
    logic [3:0][7:0] ch;
    int n;
    while (in_gaps_on && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    encode_byte(d, l, ch, n);
    if (nwant != 3'd0) begin
      for (int k = 0; k < nwant; k++)
        queue_char(want[8*(nwant-1-k) +: 8], l && (k == nwant - 1));
    end else begin
      for (int k = 0; k < n; k++)
        queue_char(ch[k], l && (k == n - 1));
    end
  endtask

  // result side: random stalls and the character check
  always @(posedge clk) begin
    b64_out_t want_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character transfer: base64_char %h last_char %b",
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        want_c = expected_chars.pop_front();
        if (out_tdata !== want_c.chr) begin
          $error("base64_char mismatch: expected %h, actual %h", want_c.chr, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want_c.last) begin
          $error("last_char mismatch: expected %b, actual %b", want_c.last, out_tlast);
          fail_count++;
        end
      end
    end
    out_tready <= !out_stall_on || ($urandom_range(99) >= 21);
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          sent;
    int          phase_no;
    int          n_msgs;
    int          msg_len;
    logic        close_msg;
    logic        quiet;
    logic [7:0]  d;
    logic [63:0] v;
    sent     = 0;
    phase_no = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].is_cfg)
        cfg_write(DIRECTED[i].idx, DIRECTED[i].val);
      else
        send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].nwant, DIRECTED[i].want);
    end

    // random messages in phases, with occasional key changes between them
    while (sent < 500) begin
      phase_no++;
      quiet        = (phase_no >= 10 && phase_no < 16);
      in_gaps_on   = !quiet;
      out_stall_on = !quiet;
      if (phase_no == 1 || $urandom_range(2) == 0) begin
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(5))
            0:       v = 64'd0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
          endcase
          cfg_write(xkb64_pkg::REG_KEY_BYTES, v);
        end
        if ($urandom_range(3) != 0) begin
          v = {$urandom, $urandom};
          case ($urandom_range(19))
            0:       v[3:0] = 4'd0;
            1:       v[3:0] = 4'($urandom_range(15, 9));
            2:       v[3:0] = 4'd1;
            3:       v[3:0] = 4'd8;
            default: v[3:0] = 4'($urandom_range(8, 1));
          endcase
          cfg_write(xkb64_pkg::REG_KEY_LENGTH, v);
        end
      end else if ($urandom_range(3) == 0) begin
        drain_results();
      end
      n_msgs = $urandom_range(4, 1);
      for (int m = 0; m < n_msgs; m++) begin
        msg_len   = ($urandom_range(7) == 0) ? $urandom_range(30, 12) : $urandom_range(9, 1);
        // the last message of a phase is sometimes left open across the pause
        close_msg = (m != n_msgs - 1) || ($urandom_range(3) != 0);
        for (int k = 0; k < msg_len; k++) begin
          case ($urandom_range(15))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = 8'($urandom_range(255));
          endcase
          send_byte(d, close_msg && (k == msg_len - 1), 3'd0, 32'h0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
src/xkb64_pkg.sv
src/xkb64_front.sv
src/xkb64_queue.sv
src/xkb64_back.sv
src/xor_key_base64_encoder.sv
tb/tb_xor_key_base64_encoder.sv
